>>> design/salc_pkg.sv
// Shared constants, codes and types of the set-associative LRU tag store.
package salc_pkg;

  // Default geometry
  localparam int MAX_SET_BITS  = 6;
  localparam int MAX_WAYS      = 4;
  localparam int ADDRESS_WIDTH = 64;
  localparam int COUNT_WIDTH   = 32;

  // Depth of the queue between classifier and lookup engine
  localparam int QUEUE_DEPTH = 2;

  // Fixed field widths
  localparam int ADDR_PORT_W = 64;
  localparam int SET_BITS_W  = 3;
  localparam int OFFSET_W    = 6;
  localparam int WAYS_W      = 3;
  localparam int CFG_DATA_W  = 6;
  localparam int CFG_IDX_W   = 2;
  localparam int OUT_CNT_W   = 32;
  localparam int RES_DATA_W  = 2 + 3 * OUT_CNT_W;
  localparam int M_TDATA_W   = ((RES_DATA_W + 7) / 8) * 8;
  localparam int M_PAD_W     = M_TDATA_W - RES_DATA_W;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

  // Request kinds
  localparam logic REQ_LOAD_STORE = 1'b0;
  localparam logic REQ_MODIFY     = 1'b1;

  // Status of one lookup result
  typedef struct packed {
    logic hit;
    logic evicted;
    logic last;
  } res_flags_t;

endpackage

>>> design/salc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module salc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/salc_fifo.sv
// Small FIFO that decouples the request classifier from the lookup engine.
module salc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = salc_pkg::QUEUE_DEPTH
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] din_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] dout_o,
  output logic             empty_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CNT_FULL);
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign dout_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= din_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("queue occupancy above depth");

  a_pop_moves_read_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop |=> rd_ptr_q != $past(rd_ptr_q) || DEPTH == 1)
    else $error("pop did not advance the read pointer");

endmodule

>>> design/salc_front.sv
// Configuration registers and request classifier: splits an address into set and tag.
module salc_front #(
  parameter int MAX_SET_BITS  = salc_pkg::MAX_SET_BITS,
  parameter int MAX_WAYS      = salc_pkg::MAX_WAYS,
  parameter int ADDRESS_WIDTH = salc_pkg::ADDRESS_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                 req_type_i,
  input  logic [salc_pkg::ADDR_PORT_W-1:0]     address_i,
  output logic [MAX_SET_BITS-1:0]              set_o,
  output logic [ADDRESS_WIDTH-2:0]             tag_o,
  output logic                                 double_o,
  output logic [$clog2(MAX_WAYS+1)-1:0]        ways_o
);

  localparam int SET_W = MAX_SET_BITS;
  localparam int TAG_W = ADDRESS_WIDTH - 1;
  localparam int SB_W  = $clog2(MAX_SET_BITS + 1);
  localparam int WC_W  = $clog2(MAX_WAYS + 1);
  localparam int SH_W  = $clog2(salc_pkg::ADDR_PORT_W + MAX_SET_BITS + 1);

  logic [salc_pkg::SET_BITS_W-1:0] set_bits_q;
  logic [salc_pkg::OFFSET_W-1:0]   offset_q;
  logic [salc_pkg::WAYS_W-1:0]     ways_q;

  logic [SB_W-1:0]          sb_eff;
  logic [SET_W-1:0]         set_mask;
  logic [ADDRESS_WIDTH-1:0] addr;
  logic [ADDRESS_WIDTH-1:0] off_addr;
  logic [ADDRESS_WIDTH-1:0] tag_full;
  logic [SH_W-1:0]          tag_shift;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q <= salc_pkg::SET_BITS_W'(1);
      offset_q   <= salc_pkg::OFFSET_W'(1);
      ways_q     <= salc_pkg::WAYS_W'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        salc_pkg::CFG_SET_BITS:    set_bits_q <= cfg_data_i[salc_pkg::SET_BITS_W-1:0];
        salc_pkg::CFG_OFFSET_BITS: offset_q   <= cfg_data_i[salc_pkg::OFFSET_W-1:0];
        salc_pkg::CFG_WAYS:        ways_q     <= cfg_data_i[salc_pkg::WAYS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp set bits and ways into the supported range
  always_comb begin
    if (set_bits_q == '0) begin
      sb_eff = SB_W'(1);
    end else if (32'(set_bits_q) > MAX_SET_BITS) begin
      sb_eff = SB_W'(MAX_SET_BITS);
    end else begin
      sb_eff = SB_W'(set_bits_q);
    end
    if (ways_q == '0) begin
      ways_o = WC_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      ways_o = WC_W'(MAX_WAYS);
    end else begin
      ways_o = WC_W'(ways_q);
    end
  end

  always_comb begin
    for (int b = 0; b < SET_W; b++) begin
      set_mask[b] = (32'(sb_eff) > b);
    end
  end

  assign addr      = address_i[ADDRESS_WIDTH-1:0];
  assign off_addr  = addr >> offset_q;
  assign set_o     = off_addr[SET_W-1:0] & set_mask;
  assign tag_shift = SH_W'(offset_q) + SH_W'(sb_eff);
  assign tag_full  = addr >> tag_shift;
  assign tag_o     = tag_full[TAG_W-1:0];
  assign double_o  = (req_type_i == salc_pkg::REQ_MODIFY);

endmodule

>>> design/salc_back.sv
// Lookup engine: reads a set, picks hit, fill or LRU victim, updates the set, keeps counts.
module salc_back #(
  parameter int MAX_SET_BITS  = salc_pkg::MAX_SET_BITS,
  parameter int MAX_WAYS      = salc_pkg::MAX_WAYS,
  parameter int ADDRESS_WIDTH = salc_pkg::ADDRESS_WIDTH,
  parameter int COUNT_WIDTH   = salc_pkg::COUNT_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               entry_valid_i,
  input  logic [MAX_SET_BITS-1:0]            set_i,
  input  logic [ADDRESS_WIDTH-2:0]           tag_i,
  input  logic                               double_i,
  input  logic [$clog2(MAX_WAYS+1)-1:0]      ways_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output salc_pkg::res_flags_t               flags_o,
  output logic [salc_pkg::OUT_CNT_W-1:0]     hits_o,
  output logic [salc_pkg::OUT_CNT_W-1:0]     misses_o,
  output logic [salc_pkg::OUT_CNT_W-1:0]     evicts_o
);

  localparam int SET_W    = MAX_SET_BITS;
  localparam int NUM_SETS = 1 << SET_W;
  localparam int TAG_W    = ADDRESS_WIDTH - 1;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int LIM_W    = RANK_W + 1;
  localparam int OUT_W    = salc_pkg::OUT_CNT_W;
  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
  localparam logic [LIM_W-1:0]  LIM_ALL  = LIM_W'(MAX_WAYS);

  typedef enum logic [1:0] {
    ST_READ = 2'b01,
    ST_LOOK = 2'b10
  } back_state_e;

  back_state_e state_q, state_d;
  logic        pass_q, pass_d;

  logic [MAX_WAYS-1:0] valid_q [NUM_SETS];

  logic [MAX_WAYS*TAG_W-1:0]  tag_rdata, tag_wdata;
  logic [MAX_WAYS*RANK_W-1:0] rank_rdata, rank_wdata;
  logic                       ram_re, tag_we, rank_we;

  logic [COUNT_WIDTH-1:0] hit_cnt_q, hit_cnt_d;
  logic [COUNT_WIDTH-1:0] miss_cnt_q, miss_cnt_d;
  logic [COUNT_WIDTH-1:0] evict_cnt_q, evict_cnt_d;

  logic                 out_valid_q;
  salc_pkg::res_flags_t flags_q;
  logic [OUT_W-1:0]     hits_q, misses_q, evicts_q;

  logic [MAX_WAYS-1:0] v_row, in_use, match, free;
  logic [RANK_W-1:0]   rank_eff [MAX_WAYS];
  logic                hit_any, fill_any, evict, last;
  logic [WAY_W-1:0]    hit_way, fill_way, victim, sel_way;
  logic [LIM_W-1:0]    limit;
  logic                do_look;

  salc_ram #(
    .WIDTH(MAX_WAYS * TAG_W),
    .DEPTH(NUM_SETS)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (tag_we),
    .waddr_i(set_i),
    .wdata_i(tag_wdata),
    .re_i   (ram_re),
    .raddr_i(set_i),
    .rdata_o(tag_rdata)
  );

  salc_ram #(
    .WIDTH(MAX_WAYS * RANK_W),
    .DEPTH(NUM_SETS)
  ) u_rank_ram (
    .clk_i  (clk_i),
    .we_i   (rank_we),
    .waddr_i(set_i),
    .wdata_i(rank_wdata),
    .re_i   (ram_re),
    .raddr_i(set_i),
    .rdata_o(rank_rdata)
  );

  assign v_row   = valid_q[set_i];
  assign ram_re  = (state_q == ST_READ) && entry_valid_i;
  assign do_look = (state_q == ST_LOOK) && (!out_valid_q || out_ready_i);
  assign last    = !double_i || pass_q;

  // Classify the ways of the set
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]   = (32'(ways_i) > w);
      rank_eff[w] = v_row[w] ? rank_rdata[w*RANK_W +: RANK_W] : '0;
      match[w]    = in_use[w] && v_row[w] && (tag_rdata[w*TAG_W +: TAG_W] == tag_i);
      free[w]     = in_use[w] && !v_row[w];
    end
  end

  // First matching way, first free way, first way of largest age
  always_comb begin
    hit_way  = '0;
    fill_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free[w]) begin
        fill_way = WAY_W'(w);
      end
    end
    victim = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_use[w] && (rank_eff[w] > rank_eff[victim])) begin
        victim = WAY_W'(w);
      end
    end
  end

  assign hit_any  = |match;
  assign fill_any = |free;
  assign evict    = !hit_any && !fill_any;

  always_comb begin
    priority if (hit_any) begin
      sel_way = hit_way;
      limit   = {1'b0, rank_eff[hit_way]};
    end else if (fill_any) begin
      sel_way = fill_way;
      limit   = LIM_ALL;
    end else begin
      sel_way = victim;
      limit   = {1'b0, rank_eff[victim]};
    end
  end

  // Age every valid in-use line more recent than the touched one
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == sel_way) begin
        rank_wdata[w*RANK_W +: RANK_W] = '0;
      end else if (in_use[w] && v_row[w] && ({1'b0, rank_eff[w]} < limit)
                   && (rank_eff[w] < RANK_MAX)) begin
        rank_wdata[w*RANK_W +: RANK_W] = rank_eff[w] + 1'b1;
      end else begin
        rank_wdata[w*RANK_W +: RANK_W] = rank_eff[w];
      end
      tag_wdata[w*TAG_W +: TAG_W] = (WAY_W'(w) == sel_way) ? tag_i
                                                            : tag_rdata[w*TAG_W +: TAG_W];
    end
  end

  assign rank_we = do_look;
  assign tag_we  = do_look && !hit_any;

  always_comb begin
    hit_cnt_d   = hit_cnt_q;
    miss_cnt_d  = miss_cnt_q;
    evict_cnt_d = evict_cnt_q;
    if (do_look) begin
      if (hit_any) begin
        hit_cnt_d = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + 1'b1;
      end else begin
        miss_cnt_d = (miss_cnt_q == '1) ? miss_cnt_q : miss_cnt_q + 1'b1;
      end
      if (evict) begin
        evict_cnt_d = (evict_cnt_q == '1) ? evict_cnt_q : evict_cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    pop_o   = 1'b0;
    unique case (state_q)
      ST_READ: begin
        if (entry_valid_i) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (do_look) begin
          state_d = ST_READ;
          if (last) begin
            pass_d = 1'b0;
            pop_o  = 1'b1;
          end else begin
            pass_d = 1'b1;
          end
        end
      end
      default: state_d = ST_READ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_READ;
      pass_q      <= 1'b0;
      out_valid_q <= 1'b0;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
      for (int s = 0; s < NUM_SETS; s++) begin
        valid_q[s] <= '0;
      end
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      hit_cnt_q   <= hit_cnt_d;
      miss_cnt_q  <= miss_cnt_d;
      evict_cnt_q <= evict_cnt_d;
      if (do_look) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (do_look && !hit_any && fill_any) begin
        valid_q[set_i][fill_way] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_look) begin
      flags_q.hit     <= hit_any;
      flags_q.evicted <= evict;
      flags_q.last    <= last;
      hits_q          <= OUT_W'(hit_cnt_d);
      misses_q        <= OUT_W'(miss_cnt_d);
      evicts_q        <= OUT_W'(evict_cnt_d);
    end
  end

  assign out_valid_o = out_valid_q;
  assign flags_o     = flags_q;
  assign hits_o      = hits_q;
  assign misses_o    = misses_q;
  assign evicts_o    = evicts_q;

  a_look_has_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOK |-> entry_valid_i)
    else $error("lookup without a queued request");

  a_evict_is_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && flags_q.evicted |-> !flags_q.hit)
    else $error("result both hit and evicted");

  a_hits_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_cnt_q >= $past(hit_cnt_q))
    else $error("hit count went down");

  a_one_count_per_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_look && hit_cnt_q != '1 && miss_cnt_q != '1
      |=> (hit_cnt_q != $past(hit_cnt_q)) != (miss_cnt_q != $past(miss_cnt_q)))
    else $error("lookup did not count exactly once");

endmodule

>>> design/set_assoc_lru_cache_tags_core.sv
// Top level of the set-associative LRU cache tag store.
// A request passes the queue, the tag/rank RAM read and the result register before its
//   result is valid on m_axis. A load or store makes one lookup, a modify two.
// Each lookup runs through ST_READ (tag/rank RAM read), then ST_LOOK (compare and write
//   back), which waits while an earlier result is held unaccepted on m_axis.
// Reset: valid bits and the hit, miss and eviction counts clear at once (no clearing
//   pass); set bits, offset bits and ways reset to one. Tags and ranks are not cleared.
module set_assoc_lru_cache_tags_core #(
  parameter int MAX_SET_BITS  = salc_pkg::MAX_SET_BITS,
  parameter int MAX_WAYS      = salc_pkg::MAX_WAYS,
  parameter int ADDRESS_WIDTH = salc_pkg::ADDRESS_WIDTH,
  parameter int COUNT_WIDTH   = salc_pkg::COUNT_WIDTH
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Configuration write port
  input  logic                               cfg_we_i,
  input  logic [salc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [salc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // Request stream
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  input  logic [salc_pkg::ADDR_PORT_W-1:0]   s_axis_tdata_i,   // [63:0] address
  input  logic                               s_axis_tuser_i,   // [0] req_type
  // Result stream
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // [0] hit, [1] evicted, [33:2] total_hits, [65:34] total_misses,
  // [97:66] total_evictions, upper bits zero
  output logic [salc_pkg::M_TDATA_W-1:0]     m_axis_tdata_o,
  output logic                               m_axis_tlast_o    // last_of_access
);

  localparam int SET_W   = MAX_SET_BITS;
  localparam int TAG_W   = ADDRESS_WIDTH - 1;
  localparam int WC_W    = $clog2(MAX_WAYS + 1);
  localparam int ENTRY_W = SET_W + TAG_W + 1;

  logic [SET_W-1:0]   front_set;
  logic [TAG_W-1:0]   front_tag;
  logic               front_double;
  logic [WC_W-1:0]    ways_eff;

  logic               q_full, q_empty, q_pop;
  logic [ENTRY_W-1:0] q_dout;

  salc_pkg::res_flags_t           res_flags;
  logic [salc_pkg::OUT_CNT_W-1:0] res_hits, res_misses, res_evicts;

  // Classify: split the address into set and tag under the current geometry
  salc_front #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDRESS_WIDTH(ADDRESS_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_type_i(s_axis_tuser_i),
    .address_i (s_axis_tdata_i),
    .set_o     (front_set),
    .tag_o     (front_tag),
    .double_o  (front_double),
    .ways_o    (ways_eff)
  );

  // Accept a request transaction whenever the queue has room
  assign s_axis_tready_o = !q_full;

  salc_fifo #(
    .WIDTH(ENTRY_W),
    .DEPTH(salc_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid_i),
    .din_i  ({front_double, front_tag, front_set}),
    .full_o (q_full),
    .pop_i  (q_pop),
    .dout_o (q_dout),
    .empty_o(q_empty)
  );

  // Lookup engine: one or two lookups per queued request, one result each
  salc_back #(
    .MAX_SET_BITS (MAX_SET_BITS),
    .MAX_WAYS     (MAX_WAYS),
    .ADDRESS_WIDTH(ADDRESS_WIDTH),
    .COUNT_WIDTH  (COUNT_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .entry_valid_i(!q_empty),
    .set_i        (q_dout[SET_W-1:0]),
    .tag_i        (q_dout[SET_W +: TAG_W]),
    .double_i     (q_dout[ENTRY_W-1]),
    .ways_i       (ways_eff),
    .pop_o        (q_pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .flags_o      (res_flags),
    .hits_o       (res_hits),
    .misses_o     (res_misses),
    .evicts_o     (res_evicts)
  );

  // Pack the result transaction
  assign m_axis_tdata_o = {{salc_pkg::M_PAD_W{1'b0}}, res_evicts, res_misses, res_hits,
                           res_flags.evicted, res_flags.hit};
  assign m_axis_tlast_o = res_flags.last;

endmodule
